>>> src/lfu_pkg.sv
// Shared sizes, types and codes for the LFU slot replacement block.
// Used by lfu_cell, lfu_min_tree and lfu_frame_replacement.
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int FRAMES     = 32;
  localparam int ID_BITS    = 8;
  localparam int COUNT_BITS = 16;

  // Register and occupancy field widths.
  localparam int CFG_W = 6;
  localparam int OCC_W = 6;

  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int LEVELS = (FRAMES > 1) ? $clog2(FRAMES) : 0;
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = 2 * LEAVES - 1;

  localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(32);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [ID_BITS-1:0]    ident_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SLOT_W-1:0]     slot_t;

  typedef struct packed {
    ident_t ident;
    count_t refs;
  } cell_data_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INC,
    OP_APPEND,
    OP_EVICT
  } cell_op_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    cell_op_t op;
    ident_t   cand;
    slot_t    target;  // append slot, or last occupied slot on evict
    slot_t    victim;
  } cell_cmd_t;

  typedef struct packed {
    logic   valid;
    slot_t  index;
    ident_t ident;
    count_t refs;
  } node_t;

endpackage

>>> src/lfu_frame_replacement.sv
// LFU slot replacement: a hit or an append is resolved in the match state,
// and a new start is taken in the cycle the result strobe is shown.
// A miss with all allowed slots full goes on to a search of the registered
// minimum tree, one level per cycle, before the result is shown.
// Sync reset empties the row and sets frames_in_use to 32; no clearing pass.
// The receiver cannot stall: done marks a result for exactly one cycle.
`timescale 1ns / 1ps

module lfu_frame_replacement
  import lfu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ID_BITS-1:0]    candidate_id,
  input  logic                  frames_in_use_we,
  input  logic [CFG_W-1:0]      frames_in_use,
  output logic                  done,
  output logic                  hit,
  output logic                  evicted_valid,
  output logic [ID_BITS-1:0]    evicted_id,
  output logic [COUNT_BITS-1:0] evicted_count,
  output logic [COUNT_BITS-1:0] new_count,
  output logic [OCC_W-1:0]      occupancy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SEARCH
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] limit_cfg;
  logic [CNT_W-1:0] occ;
  ident_t           cand;

  cell_cmd_t        cmd;
  cell_data_t       cells [FRAMES];
  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] occ_vec;
  node_t            leaves [FRAMES];
  logic             tree_done;
  node_t            tree_best;

  logic             any_hit;
  count_t           hit_refs;
  count_t           hit_next;
  logic [CMP_W-1:0] lim;
  logic [CMP_W-1:0] occ_ext;
  logic             full;
  logic [CNT_W-1:0] occ_dec;
  logic             tree_start;

  assign busy = (state != S_IDLE);

  for (genvar i = 0; i < FRAMES; i++) begin : g_row
    cell_data_t nbr;
    if (i < FRAMES - 1) begin : g_mid
      assign nbr = cells[i+1];
    end else begin : g_end
      assign nbr = '0;
    end

    assign occ_vec[i] = (CNT_W'(i) < occ);
    assign leaves[i]  = '{valid: occ_vec[i], index: slot_t'(i),
                          ident: cells[i].ident, refs: cells[i].refs};

    lfu_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .slot_index (slot_t'(i)),
      .occupied   (occ_vec[i]),
      .cmd        (cmd),
      .nbr        (nbr),
      .data       (cells[i]),
      .match      (match[i])
    );
  end

  lfu_min_tree u_tree (
    .clk    (clk),
    .rst    (rst),
    .start  (tree_start),
    .leaves (leaves),
    .done   (tree_done),
    .best   (tree_best)
  );

  // Held identifiers are unique, so at most one match bit is set.
  always_comb begin
    hit_refs = '0;
    for (int i = 0; i < FRAMES; i++) begin
      hit_refs = hit_refs | (match[i] ? cells[i].refs : '0);
    end
  end

  assign any_hit  = |match;
  assign hit_next = (hit_refs == COUNT_MAX) ? hit_refs : hit_refs + 1'b1;

  always_comb begin
    if (limit_cfg == '0) begin
      lim = CMP_W'(1);
    end else if (CMP_W'(limit_cfg) > CMP_W'(FRAMES)) begin
      lim = CMP_W'(FRAMES);
    end else begin
      lim = CMP_W'(limit_cfg);
    end
  end

  assign occ_ext    = CMP_W'(occ);
  assign full       = (occ_ext >= lim) && (occ != '0);
  assign occ_dec    = occ - 1'b1;
  assign tree_start = (state == S_MATCH) && !any_hit && full;

  always_comb begin
    cmd = '{op: OP_HOLD, cand: cand, target: occ[SLOT_W-1:0], victim: tree_best.index};
    case (state)
      S_MATCH: begin
        if (any_hit) begin
          cmd.op = OP_INC;
        end else if (!full) begin
          cmd.op = OP_APPEND;
        end
      end
      S_SEARCH: begin
        if (tree_done) begin
          cmd.op     = OP_EVICT;
          cmd.target = occ_dec[SLOT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      occ       <= '0;
      limit_cfg <= CFG_RESET;
    end else begin
      done <= 1'b0;
      if (frames_in_use_we) begin
        limit_cfg <= frames_in_use;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cand  <= candidate_id;
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (any_hit) begin
            done          <= 1'b1;
            hit           <= 1'b1;
            evicted_valid <= 1'b0;
            evicted_id    <= '0;
            evicted_count <= '0;
            new_count     <= hit_next;
            occupancy     <= OCC_W'(occ);
            state         <= S_IDLE;
          end else if (!full) begin
            done          <= 1'b1;
            hit           <= 1'b0;
            evicted_valid <= 1'b0;
            evicted_id    <= '0;
            evicted_count <= '0;
            new_count     <= count_t'(1);
            occupancy     <= OCC_W'(occ + 1'b1);
            occ           <= occ + 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // Evict and append: occupancy is unchanged.
          if (tree_done) begin
            done          <= 1'b1;
            hit           <= 1'b0;
            evicted_valid <= 1'b1;
            evicted_id    <= tree_best.ident;
            evicted_count <= tree_best.refs;
            new_count     <= count_t'(1);
            occupancy     <= OCC_W'(occ);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (occ != '0))
    else $error("eviction search with empty row");

  a_tree_in_search: assert property (@(posedge clk) disable iff (rst)
    tree_done |-> (state == S_SEARCH))
    else $error("tree result outside search");

  a_victim_occupied: assert property (@(posedge clk) disable iff (rst)
    tree_done |-> (tree_best.valid && (CNT_W'(tree_best.index) < occ)))
    else $error("victim is not an occupied slot");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(FRAMES))
    else $error("occupancy above slot count");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (!evicted_valid && new_count != '0))
    else $error("hit beat reports an eviction");

endmodule

>>> src/lfu_cell.sv
// One slot of the age-ordered row: identifier, count, match compare.
// Depends on lfu_pkg; takes its younger neighbor's contents on eviction.
`timescale 1ns / 1ps

module lfu_cell
  import lfu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  slot_t      slot_index,
  input  logic       occupied,
  input  cell_cmd_t  cmd,
  input  cell_data_t nbr,
  output cell_data_t data,
  output logic       match
);

  ident_t ident;
  count_t refs;

  assign data  = '{ident: ident, refs: refs};
  assign match = occupied && (ident == cmd.cand);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_APPEND: begin
        if (slot_index == cmd.target) begin
          ident <= cmd.cand;
        end
      end
      OP_EVICT: begin
        if (slot_index == cmd.target) begin
          ident <= cmd.cand;
        end else if (slot_index >= cmd.victim && slot_index < cmd.target) begin
          ident <= nbr.ident;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refs <= '0;
    end else begin
      case (cmd.op)
        OP_INC: begin
          if (match && refs != COUNT_MAX) begin
            refs <= refs + 1'b1;
          end
        end
        OP_APPEND: begin
          if (slot_index == cmd.target) begin
            refs <= count_t'(1);
          end
        end
        OP_EVICT: begin
          if (slot_index == cmd.target) begin
            refs <= count_t'(1);
          end else if (slot_index >= cmd.victim && slot_index < cmd.target) begin
            refs <= nbr.refs;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/lfu_min_tree.sv
// Registered binary tree that finds the oldest slot with the least count.
// Depends on lfu_pkg; one tree level per cycle, lower index wins a tie.
`timescale 1ns / 1ps

module lfu_min_tree
  import lfu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  node_t leaves [FRAMES],
  output logic  done,
  output node_t best
);

  // Heap layout: node n has children 2n+1 and 2n+2, leaves at LEAVES-1 on.
  node_t heap [NODES];
  logic [LEVELS:0] vpipe;

  function automatic node_t pick(input node_t a, input node_t b);
    node_t r;
    if (!a.valid) begin
      r = b;
    end else if (!b.valid) begin
      r = a;
    end else if (a.refs <= b.refs) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_inner
    always_ff @(posedge clk) begin
      heap[n] <= pick(heap[2*n+1], heap[2*n+2]);
    end
  end

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < FRAMES) begin : g_real
      always_ff @(posedge clk) begin
        heap[LEAVES-1+j] <= leaves[j];
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        heap[LEAVES-1+j] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe[0] <= start;
      for (int k = 1; k <= LEVELS; k++) begin
        vpipe[k] <= vpipe[k-1];
      end
    end
  end

  assign done = vpipe[LEVELS];
  assign best = heap[0];

endmodule
